FILE: rtl/rtce_pkg.sv
// Shared types and constants of the radio tuning command encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rtce_pkg;

    // Field widths
    localparam int FREQ_W   = 29;
    localparam int OFFS_W   = 15;
    localparam int STEP_W   = 14;
    localparam int OPC_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 29;
    localparam int BYTE_W   = 8;

    // Working width of signed frequency and offset arithmetic
    localparam int SUM_W    = FREQ_W + 2;

    // Binary to BCD conversion pipeline
    localparam int DD_BIN_W          = 32;
    localparam int DD_DIGITS         = 9;
    localparam int DD_BCD_W          = DD_DIGITS * 4;
    localparam int DD_BITS_PER_STAGE = 4;
    localparam int DD_STAGES         = DD_BIN_W / DD_BITS_PER_STAGE;

    // Limits
    localparam logic [SUM_W-2:0]        FREQ_MAX_HZ = (SUM_W-1)'(500000000);
    localparam logic signed [SUM_W-1:0] CLAR_HI     = SUM_W'(9999);
    localparam logic signed [SUM_W-1:0] CLAR_LO     = -(SUM_W'(9999));

    // Register reset values
    localparam logic [FREQ_W-1:0]        RST_BASE_FREQ = '0;
    localparam logic signed [OFFS_W-1:0] RST_BASE_OFFS = -(OFFS_W'(1500));
    localparam logic [STEP_W-1:0]        RST_STEP      = STEP_W'(5000);
    localparam logic                     RST_PWR_EN    = 1'b0;

    // Command bytes
    localparam logic [BYTE_W-1:0] CODE_SET_FREQ = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_CLAR     = 8'hF5;
    localparam logic [BYTE_W-1:0] CODE_INIT     = 8'h07;
    localparam logic [BYTE_W-1:0] INIT_LEAD     = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_INIT_END = 8'h05;
    localparam logic [BYTE_W-1:0] CODE_WAKE     = 8'h00;
    localparam logic [BYTE_W-1:0] CODE_PWR_ON   = 8'h0F;
    localparam logic [BYTE_W-1:0] CODE_PWR_OFF  = 8'h8F;
    localparam logic [BYTE_W-1:0] SIGN_POS      = 8'h00;
    localparam logic [BYTE_W-1:0] SIGN_NONPOS   = 8'h01;
    localparam logic [BYTE_W-1:0] CLAR_SAT_HI   = 8'h99;
    localparam logic [BYTE_W-1:0] CLAR_SAT_LO   = 8'h90;

    typedef enum logic [OPC_W-1:0] {
        OP_RETUNE  = 2'd0,
        OP_INIT    = 2'd1,
        OP_PWR_ON  = 2'd2,
        OP_PWR_OFF = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_FREQ = 2'd0,
        CFG_BASE_OFFS = 2'd1,
        CFG_STEP      = 2'd2,
        CFG_PWR_EN    = 2'd3
    } cfg_idx_t;

    // Per-item decisions carried down the conversion pipeline
    typedef struct packed {
        opcode_t op;
        logic    freq_ok;
        logic    clar_ok;
        logic    clar_sign;
        logic    pwr_en;
    } cmd_ctl_t;

    typedef struct packed {
        cmd_ctl_t              ctl;
        logic [DD_BIN_W-1:0]   frq_bin;
        logic [DD_BCD_W-1:0]   frq_bcd;
        logic [DD_BIN_W-1:0]   clr_bin;
        logic [DD_BCD_W-1:0]   clr_bcd;
    } lane_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic [BYTE_W-1:0] byte_c;
        logic [BYTE_W-1:0] byte_d;
        logic [BYTE_W-1:0] code;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/rtce_if.sv
// Valid/ready channel interfaces of the radio tuning command encoder.
// Depends on rtce_pkg for field widths.
`default_nettype none

interface rtce_in_if
    import rtce_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OPC_W-1:0]     opcode;
    logic [FREQ_W-1:0]    target_frequency;

    modport source (output valid, output opcode, output target_frequency, input ready);
    modport sink   (input valid, input opcode, input target_frequency, output ready);
endinterface

interface rtce_out_if
    import rtce_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    param_byte_a;
    logic [BYTE_W-1:0]    param_byte_b;
    logic [BYTE_W-1:0]    param_byte_c;
    logic [BYTE_W-1:0]    param_byte_d;
    logic [BYTE_W-1:0]    command_code;
    logic                 last_of_run;

    modport source (output valid, output param_byte_a, output param_byte_b,
                    output param_byte_c, output param_byte_d, output command_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input param_byte_a, input param_byte_b,
                    input param_byte_c, input param_byte_d, input command_code,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/radio_tuning_command_encoder_top.sv
// Radio tuning command encoder: input register and decision stage, an 8-stage
// binary to BCD pipeline, then a sequencer with an output register.
// Throughput: one command per cycle unless cmd_out.ready stalls; an item holds the sequencer
// until its commands (1 to 4) are sent, and an item with no command still takes its turn.
// Reset: rst_n async low clears control, base frequency and registers to defaults.
`default_nettype none

module radio_tuning_command_encoder_top
    import rtce_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    rtce_in_if.sink                    cmd_in,
    rtce_out_if.source                 cmd_out
);

    lane_t lane       [DD_STAGES+1];
    logic  lane_valid [DD_STAGES+1];
    logic  lane_ready [DD_STAGES+1];
    cmd_t  out_cmd;

    rtce_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .up_valid  (cmd_in.valid),
        .up_ready  (cmd_in.ready),
        .up_opcode (cmd_in.opcode),
        .up_target (cmd_in.target_frequency),
        .dn_valid  (lane_valid[0]),
        .dn_ready  (lane_ready[0]),
        .dn_lane   (lane[0])
    );

    for (genvar s = 0; s < DD_STAGES; s++)
    begin : g_bcd
        rtce_bcd_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (lane_valid[s]),
            .up_ready (lane_ready[s]),
            .up_lane  (lane[s]),
            .dn_valid (lane_valid[s+1]),
            .dn_ready (lane_ready[s+1]),
            .dn_lane  (lane[s+1])
        );
    end

    rtce_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (lane_valid[DD_STAGES]),
        .up_ready  (lane_ready[DD_STAGES]),
        .up_lane   (lane[DD_STAGES]),
        .out_valid (cmd_out.valid),
        .out_ready (cmd_out.ready),
        .out_cmd   (out_cmd),
        .out_last  (cmd_out.last_of_run)
    );

    assign cmd_out.param_byte_a = out_cmd.byte_a;
    assign cmd_out.param_byte_b = out_cmd.byte_b;
    assign cmd_out.param_byte_c = out_cmd.byte_c;
    assign cmd_out.param_byte_d = out_cmd.byte_d;
    assign cmd_out.command_code = out_cmd.code;

endmodule

`default_nettype wire

FILE: rtl/rtce_decide.sv
// Input register, configuration registers, base frequency and per-item decisions.
// Depends on rtce_pkg; feeds the BCD conversion pipeline.
`default_nettype none

module rtce_decide
    import rtce_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  up_valid,
    output logic                       up_ready,
    input  wire logic [OPC_W-1:0]      up_opcode,
    input  wire logic [FREQ_W-1:0]     up_target,
    output logic                       dn_valid,
    input  wire logic                  dn_ready,
    output lane_t                      dn_lane
);

    logic [FREQ_W-1:0]        base_freq_reg;
    logic signed [OFFS_W-1:0] base_offs_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     pwr_en_reg;
    logic [FREQ_W-1:0]        cur_base_reg;
    logic [FREQ_W-1:0]        cur_base_next;

    logic                     in_valid_reg;
    opcode_t                  op_reg;
    logic [FREQ_W-1:0]        tgt_reg;

    logic                     d_valid_reg;
    lane_t                    d_lane_reg;
    lane_t                    d_lane_next;

    logic                     d_ready;
    logic                     adv;

    logic [FREQ_W:0]          diff;
    logic [FREQ_W:0]          abs_diff;
    logic                     move;
    logic                     up_dir;
    logic [SUM_W-1:0]         f_ret;
    logic [SUM_W-1:0]         f_init;
    logic [SUM_W-1:0]         f_sel;
    logic                     f_in_range;
    logic                     freq_ok;
    logic signed [SUM_W-1:0]  off_full;
    logic                     clar_ok;
    logic [15:0]              rnd_n;
    logic [15:0]              rnd_u;

    assign d_ready  = !d_valid_reg || dn_ready;
    assign adv      = in_valid_reg && d_ready;
    assign up_ready = !in_valid_reg || d_ready;

    always_comb
    begin
        diff     = {1'b0, tgt_reg} - {1'b0, cur_base_reg};
        abs_diff = diff[FREQ_W] ? (~diff + 1'b1) : diff;
        move     = abs_diff > {{(FREQ_W + 1 - STEP_W){1'b0}}, step_reg};
        up_dir   = tgt_reg > cur_base_reg;

        f_ret  = up_dir ? ({2'b00, tgt_reg} + {{(SUM_W - STEP_W){1'b0}}, step_reg})
                        : ({2'b00, tgt_reg} - {{(SUM_W - STEP_W){1'b0}}, step_reg});
        f_init = {2'b00, base_freq_reg}
               + {{(SUM_W - OFFS_W){base_offs_reg[OFFS_W-1]}}, base_offs_reg};
        f_sel  = (op_reg == OP_INIT) ? f_init : f_ret;

        // Reject bases that went negative or above the top of the band
        f_in_range = !f_sel[SUM_W-1] && (f_sel[SUM_W-2:0] <= FREQ_MAX_HZ);
        freq_ok    = f_in_range && ((op_reg == OP_INIT) || ((op_reg == OP_RETUNE) && move));

        cur_base_next = freq_ok ? f_sel[FREQ_W-1:0] : cur_base_reg;

        off_full = $signed({2'b00, tgt_reg} - {2'b00, cur_base_next});
        clar_ok  = (off_full <= CLAR_HI) && (off_full >= CLAR_LO);

        // Round to 10 Hz, ties up: keep the tens of n for n >= 0, of 9 - n below zero
        rnd_n = off_full[15:0] + 16'd5;
        rnd_u = rnd_n[15] ? (16'd9 - rnd_n) : rnd_n;

        d_lane_next.ctl.op        = op_reg;
        d_lane_next.ctl.freq_ok   = freq_ok;
        d_lane_next.ctl.clar_ok   = clar_ok;
        d_lane_next.ctl.clar_sign = off_full[SUM_W-1] || (off_full == '0);
        d_lane_next.ctl.pwr_en    = pwr_en_reg;
        d_lane_next.frq_bin       = {{(DD_BIN_W - FREQ_W){1'b0}}, f_sel[FREQ_W-1:0]};
        d_lane_next.frq_bcd       = '0;
        d_lane_next.clr_bin       = {{(DD_BIN_W - 16){1'b0}}, rnd_u};
        d_lane_next.clr_bcd       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_freq_reg <= RST_BASE_FREQ;
            base_offs_reg <= RST_BASE_OFFS;
            step_reg      <= RST_STEP;
            pwr_en_reg    <= RST_PWR_EN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE_FREQ: base_freq_reg <= cfg_wdata[FREQ_W-1:0];
                CFG_BASE_OFFS: base_offs_reg <= $signed(cfg_wdata[OFFS_W-1:0]);
                CFG_STEP:      step_reg      <= cfg_wdata[STEP_W-1:0];
                CFG_PWR_EN:    pwr_en_reg    <= cfg_wdata[0];
                default:       pwr_en_reg    <= pwr_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            d_valid_reg  <= 1'b0;
            cur_base_reg <= '0;
        end
        else
        begin
            if (up_ready)
            begin
                in_valid_reg <= up_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= in_valid_reg;
            end
            // The moved base is registered, so the next item sees it
            if (adv)
            begin
                cur_base_reg <= cur_base_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            op_reg  <= opcode_t'(up_opcode);
            tgt_reg <= up_target;
        end
        if (adv)
        begin
            d_lane_reg <= d_lane_next;
        end
    end

    assign dn_valid = d_valid_reg;
    assign dn_lane  = d_lane_reg;

endmodule

`default_nettype wire

FILE: rtl/rtce_bcd_stage.sv
// One stage of the shift-and-add-3 binary to BCD pipeline, two lanes.
// Depends on rtce_pkg for the lane layout and stage sizing.
`default_nettype none

module rtce_bcd_stage
    import rtce_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_ready,
    input  wire lane_t up_lane,
    output logic       dn_valid,
    input  wire logic  dn_ready,
    output lane_t      dn_lane
);

    logic  valid_reg;
    lane_t lane_reg;
    lane_t lane_next;

    // Shift a few binary bits into the BCD digits, adding 3 to digits of 5 or more
    function automatic logic [DD_BCD_W+DD_BIN_W-1:0] dd_shift(
        input logic [DD_BCD_W-1:0] bcd_in,
        input logic [DD_BIN_W-1:0] bin_in
    );
        logic [DD_BCD_W-1:0] bcd;
        logic [DD_BIN_W-1:0] bin;
        bcd = bcd_in;
        bin = bin_in;
        for (int s = 0; s < DD_BITS_PER_STAGE; s++)
        begin
            for (int g = 0; g < DD_DIGITS; g++)
            begin
                if (bcd[g*4 +: 4] >= 4'd5)
                begin
                    bcd[g*4 +: 4] = bcd[g*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[DD_BCD_W-2:0], bin[DD_BIN_W-1]};
            bin = {bin[DD_BIN_W-2:0], 1'b0};
        end
        return {bcd, bin};
    endfunction

    always_comb
    begin
        lane_next     = up_lane;
        {lane_next.frq_bcd, lane_next.frq_bin} = dd_shift(up_lane.frq_bcd, up_lane.frq_bin);
        {lane_next.clr_bcd, lane_next.clr_bin} = dd_shift(up_lane.clr_bcd, up_lane.clr_bin);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            lane_reg <= lane_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_lane  = lane_reg;

endmodule

`default_nettype wire

FILE: rtl/rtce_sequencer.sv
// Builds the command run of one item and sends it out one command per transfer.
// Depends on rtce_pkg for the lane, command types and command bytes.
`default_nettype none

module rtce_sequencer
    import rtce_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         up_valid,
    output logic              up_ready,
    input  wire lane_t        up_lane,
    output logic              out_valid,
    input  wire logic         out_ready,
    output cmd_t              out_cmd,
    output logic              out_last
);

    localparam int SLOTS = 4;

    logic [SLOTS-1:0] mask_reg;
    cmd_t             slot_reg [SLOTS];
    logic [SLOTS-1:0] mask_next;
    cmd_t             slot_next [SLOTS];

    logic             out_valid_reg;
    cmd_t             out_cmd_reg;
    logic             out_last_reg;

    logic [1:0]       sel;
    logic [SLOTS-1:0] rest;
    logic             out_load;
    logic             emit;

    cmd_t             freq_cmd;
    cmd_t             clar_cmd;
    logic             clar_sat;

    // Frequency digits: drop the units digit to send Hz / 10
    always_comb
    begin
        freq_cmd.byte_a = up_lane.frq_bcd[35:28];
        freq_cmd.byte_b = up_lane.frq_bcd[27:20];
        freq_cmd.byte_c = up_lane.frq_bcd[19:12];
        freq_cmd.byte_d = up_lane.frq_bcd[11:4];
        freq_cmd.code   = CODE_SET_FREQ;

        // A nonzero ten-thousands digit means a rounded magnitude of 10000
        clar_sat        = up_lane.clr_bcd[19:16] != 4'd0;
        clar_cmd.byte_a = up_lane.ctl.clar_sign ? SIGN_NONPOS : SIGN_POS;
        clar_cmd.byte_b = '0;
        clar_cmd.byte_c = clar_sat ? CLAR_SAT_HI : up_lane.clr_bcd[15:8];
        clar_cmd.byte_d = clar_sat ? CLAR_SAT_LO : {up_lane.clr_bcd[7:4], 4'h0};
        clar_cmd.code   = CODE_CLAR;
    end

    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_next[i] = '0;
        end
        unique case (up_lane.ctl.op)
            OP_RETUNE:
            begin
                slot_next[0] = freq_cmd;
                slot_next[1] = clar_cmd;
                mask_next    = {2'b00, up_lane.ctl.clar_ok, up_lane.ctl.freq_ok};
            end
            OP_INIT:
            begin
                slot_next[0]        = '0;
                slot_next[0].byte_a = INIT_LEAD;
                slot_next[0].code   = CODE_INIT;
                slot_next[1]        = freq_cmd;
                slot_next[2].code   = CODE_CLAR;
                slot_next[3].code   = CODE_INIT_END;
                mask_next           = {2'b11, up_lane.ctl.freq_ok, 1'b1};
            end
            OP_PWR_ON:
            begin
                slot_next[0].code = CODE_WAKE;
                slot_next[1].code = CODE_PWR_ON;
                mask_next         = {2'b00, {2{up_lane.ctl.pwr_en}}};
            end
            OP_PWR_OFF:
            begin
                slot_next[0].code = CODE_PWR_OFF;
                mask_next         = {3'b000, up_lane.ctl.pwr_en};
            end
            default:
            begin
                mask_next = '0;
            end
        endcase
    end

    // Lowest pending slot goes first
    always_comb
    begin
        priority if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else if (mask_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        rest = mask_reg & ~(SLOTS'(1) << sel);
    end

    assign out_load = !out_valid_reg || out_ready;
    assign emit     = (mask_reg != '0) && out_load;
    assign up_ready = (mask_reg == '0) || (emit && (rest == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_valid && up_ready)
            begin
                mask_reg <= mask_next;
            end
            else if (emit)
            begin
                mask_reg <= rest;
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
        if (emit)
        begin
            out_cmd_reg  <= slot_reg[sel];
            out_last_reg <= rest == '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cmd   = out_cmd_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire
